// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clock and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define KESC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition must never be seen at a clock edge outside reset
`define KESC_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ===== rtl/core/kesc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kesc_pkg
// types and constants shared by the keypad edge slot controller
// ----------------------------------------------------------------------------
package kesc_pkg;

   localparam int WORD_W     = 32;
   localparam int ECHO_DEPTH = 16;
   localparam int IDX_W      = 4;
   localparam int NUM_SLOTS  = 4;
   localparam int SLOT_W     = 2;
   localparam int KEY_W      = 3;
   localparam int KEY_ID_W   = 2 * KEY_W;
   localparam int EDGE_W     = 2 * NUM_SLOTS;

   // command codes carried on the request tuser
   typedef enum logic [2:0] {
      CMD_PRESS   = 3'd0,
      CMD_RELEASE = 3'd1,
      CMD_END_DN  = 3'd2,
      CMD_END_UP  = 3'd3,
      CMD_READ    = 3'd4,
      CMD_WRITE   = 3'd5
   } cmd_type;

   // event status codes
   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_DROPPED  = 2'd1,
      STAT_HELD     = 2'd2,
      STAT_NOT_HELD = 2'd3
   } status_type;

   // register word indexes with special behaviour
   localparam logic [IDX_W-1:0] REG_EDGE     = 4'd2;
   localparam logic [IDX_W-1:0] REG_CLEAR    = 4'd4;
   localparam logic [IDX_W-1:0] REG_STATUS   = 4'd11;
   localparam logic [IDX_W-1:0] REG_UNMAPPED = 4'd15;

   // echo bank write port
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [WORD_W-1:0] data;
   } echo_wr_type;

   // echo bank read port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } echo_rd_type;

   // response fields waiting for the echo bank read
   typedef struct packed {
      logic              echo_sel;
      logic [WORD_W-1:0] rdata;
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic              end_level;
      logic              end_changed;
   } rsp_stage_type;

endpackage

// ===== rtl/core/kesc_echo_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kesc_echo_ram
// sixteen-word store-and-echo register bank, one write and one registered
// read per cycle, with per-word valid bits so unwritten words read as zero
// ----------------------------------------------------------------------------
module kesc_echo_ram (
   input  logic                          clock,
   input  logic                          reset,
   input  kesc_pkg::echo_wr_type         wr_req,
   input  kesc_pkg::echo_rd_type         rd_req,
   output logic [kesc_pkg::WORD_W-1:0]   rd_data
);
   import kesc_pkg::*;

   logic [WORD_W-1:0]     mem_ff [ECHO_DEPTH];
   logic [ECHO_DEPTH-1:0] valid_ff;
   logic [WORD_W-1:0]     rd_word_ff;
   logic                  rd_valid_ff;

   // word array, no reset
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem_ff[wr_req.addr] <= wr_req.data;
      end
   end

   // written marks, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_req.en) begin
         valid_ff[wr_req.addr] <= 1'b1;
      end
   end

   // registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_word_ff <= mem_ff[rd_req.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_req.en) begin
         rd_valid_ff <= valid_ff[rd_req.addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// ===== rtl/core/keypad_edge_slot_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_edge_slot_controller
// keypad matrix controller with four key slots and their edge latches, an END key level and a
// sixteen-word register bank, one key event or bus access per word
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  req_    | in        | key event or register access (command on tuser)
//  rsp_    | out       | read data, event status, slot, END level and change
//
//  one word accepted per cycle unless the middle stage is stalled; its response
//  passes the middle stage (bank read at the accepting edge), then the output register
//  slot, latch, status and END state update at the accepting edge, so the
//  next word sees them at once; the bank write lands before any later read
//  synchronous reset clears key state, valid flags and the bank's written marks at once,
//  no clearing pass
//  a stalled rsp_ holds the output register; req_ still takes a word while
//  the middle stage is free
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_edge_slot_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] command
   input  logic [47:0] req_tdata,   // [2:0] key_row, [5:3] key_col,
                                    // [9:6] reg_index, [41:10] write_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] read_data, [33:32] event_status,
                                    // [35:34] slot_used, [36] end_level,
                                    // [37] end_changed
);
   import kesc_pkg::*;

   // request fields
   cmd_type             cmd;
   logic [KEY_W-1:0]    req_key_row;
   logic [KEY_W-1:0]    req_key_col;
   logic [IDX_W-1:0]    req_reg_index;
   logic [WORD_W-1:0]   req_write_data;
   logic [KEY_ID_W-1:0] key_id;

   assign cmd            = cmd_type'(req_tuser);
   assign req_key_row    = req_tdata[2:0];
   assign req_key_col    = req_tdata[5:3];
   assign req_reg_index  = req_tdata[9:6];
   assign req_write_data = req_tdata[41:10];
   assign key_id         = {req_key_row, req_key_col};

   // key state
   logic [NUM_SLOTS-1:0] slot_busy_ff, slot_busy_in;
   logic [KEY_ID_W-1:0]  slot_key_ff [NUM_SLOTS];
   logic [KEY_ID_W-1:0]  slot_key_in [NUM_SLOTS];
   logic [EDGE_W-1:0]    edge_latch_ff, edge_latch_in;
   logic [WORD_W-1:0]    status_word_ff, status_word_in;
   logic                 end_level_ff, end_level_in;

   // pipeline control
   logic          req_accept;
   logic          s1_valid_ff, s1_adv;
   rsp_stage_type s1_ff, s1_in;
   logic          out_valid_ff;
   logic [39:0]   out_data_ff;

   // echo bank ports
   echo_wr_type       echo_wr;
   echo_rd_type       echo_rd;
   logic [WORD_W-1:0] echo_rd_data;
   logic              echo_idx_ok;

   // slot search results
   logic                 free_any, held_any;
   logic [SLOT_W-1:0]    free_slot, held_slot;
   logic                 press_ok, clear_wr;
   logic [7:0]           row_byte;
   logic [4:0]           byte_shift;

   assign s1_adv     = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;

   // indexes backed by the echo bank
   assign echo_idx_ok = (req_reg_index != REG_EDGE) && (req_reg_index != REG_CLEAR) &&
                        (req_reg_index != REG_STATUS) && (req_reg_index != REG_UNMAPPED);

   // free slot: own column first, else lowest free; held slot: lowest match
   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      held_any  = 1'b0;
      held_slot = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!slot_busy_ff[i]) begin
            free_any  = 1'b1;
            free_slot = SLOT_W'(i);
         end
         if (slot_busy_ff[i] && (slot_key_ff[i] == key_id)) begin
            held_any  = 1'b1;
            held_slot = SLOT_W'(i);
         end
      end
      if (!req_key_col[KEY_W-1] && !slot_busy_ff[req_key_col[SLOT_W-1:0]]) begin
         free_slot = req_key_col[SLOT_W-1:0];
      end
   end

   assign press_ok   = (cmd == CMD_PRESS) && free_any && !held_any;
   assign clear_wr   = (cmd == CMD_WRITE) && (req_reg_index == REG_CLEAR);
   assign row_byte   = {1'b0, req_key_row, 1'b0, req_key_col};
   assign byte_shift = {free_slot, 3'b000};

   // next state and response fields for one word
   always_comb begin
      slot_busy_in   = slot_busy_ff;
      slot_key_in    = slot_key_ff;
      edge_latch_in  = edge_latch_ff;
      status_word_in = status_word_ff;
      end_level_in   = end_level_ff;
      s1_in          = '0;
      s1_in.status   = STAT_DONE;
      unique case (cmd)
         CMD_PRESS: begin
            if (!free_any) begin
               s1_in.status = STAT_DROPPED;
            end else if (held_any) begin
               s1_in.status = STAT_HELD;
            end else begin
               slot_busy_in[free_slot] = 1'b1;
               slot_key_in[free_slot]  = key_id;
               edge_latch_in           = edge_latch_ff | (EDGE_W'(1) << free_slot);
               status_word_in          = (status_word_ff & ~(WORD_W'(8'hff) << byte_shift))
                                         | (WORD_W'(row_byte) << byte_shift);
               s1_in.slot              = free_slot;
            end
         end
         CMD_RELEASE: begin
            if (!held_any) begin
               s1_in.status = STAT_NOT_HELD;
            end else begin
               slot_busy_in[held_slot] = 1'b0;
               edge_latch_in = edge_latch_ff | (EDGE_W'(1) << {1'b1, held_slot});
               s1_in.slot    = held_slot;
            end
         end
         CMD_END_DN, CMD_END_UP: begin
            end_level_in      = (cmd == CMD_END_DN);
            s1_in.end_changed = (end_level_in != end_level_ff);
         end
         CMD_READ: begin
            s1_in.echo_sel = echo_idx_ok;
            if (req_reg_index == REG_EDGE) begin
               s1_in.rdata = WORD_W'(edge_latch_ff);
            end else if (req_reg_index == REG_STATUS) begin
               s1_in.rdata = status_word_ff;
            end
         end
         CMD_WRITE: begin
            if (clear_wr) begin
               edge_latch_in = '0;
            end
         end
         default: begin
         end
      endcase
      s1_in.end_level = end_level_in;
   end

   // echo bank access at the accepting edge
   assign echo_wr.en   = req_accept && (cmd == CMD_WRITE) && echo_idx_ok;
   assign echo_wr.addr = req_reg_index;
   assign echo_wr.data = req_write_data;
   assign echo_rd.en   = req_accept && (cmd == CMD_READ);
   assign echo_rd.addr = req_reg_index;

   kesc_echo_ram u_echo_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_req  (echo_wr),
      .rd_req  (echo_rd),
      .rd_data (echo_rd_data)
   );

   // key state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_busy_ff   <= '0;
         edge_latch_ff  <= '0;
         status_word_ff <= '0;
         end_level_ff   <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_key_ff[i] <= '0;
         end
      end else if (req_accept) begin
         slot_busy_ff   <= slot_busy_in;
         edge_latch_ff  <= edge_latch_in;
         status_word_ff <= status_word_in;
         end_level_ff   <= end_level_in;
         slot_key_ff    <= slot_key_in;
      end
   end

   // middle stage, waits for the bank read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_data_ff <= {2'b00, s1_ff.end_changed, s1_ff.end_level, s1_ff.slot,
                         s1_ff.status, (s1_ff.echo_sel ? echo_rd_data : s1_ff.rdata)};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // checks
   `KESC_ASSERT(a_press_sets_busy, (req_accept && press_ok) |=> slot_busy_ff[$past(free_slot)], "press did not mark its slot busy")
   `KESC_ASSERT(a_clear_zeroes_latch, (req_accept && clear_wr) |=> (edge_latch_ff == '0), "clear write left edge latch set")
   `KESC_ASSERT_NEVER(a_no_accept_on_stall, s1_valid_ff && !s1_adv && req_accept, "word taken while middle stage stalled")

endmodule
